// ===== sv/csac_pkg.sv =====
// ----------------------------------------------------------------------------
// csac_pkg
// Shared types and constants for the coherent set-associative cache.
// ----------------------------------------------------------------------------
package csac_pkg;

   localparam int WAYS_LOG2_DEF       = 2;
   localparam int SETS_LOG2_DEF       = 6;
   localparam int LINE_BYTES_LOG2_DEF = 3;

   localparam logic [2:0] OP_LOAD      = 3'd0;
   localparam logic [2:0] OP_STORE     = 3'd1;
   localparam logic [2:0] OP_FILL      = 3'd2;
   localparam logic [2:0] OP_SNOOP_INV = 3'd3;
   localparam logic [2:0] OP_SNOOP_RD  = 3'd4;

   localparam logic [1:0] PERM_INV = 2'd0;
   localparam logic [1:0] PERM_SHR = 2'd1;
   localparam logic [1:0] PERM_EXC = 2'd2;
   localparam logic [1:0] PERM_MOD = 2'd3;

   localparam logic       CMD_READ  = 1'b0;
   localparam logic       CMD_WBACK = 1'b1;
   localparam logic [15:0] WB_TAG   = 16'hFFFF;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [31:0] address;
      logic [7:0]  store_byte;
      logic        retried;
      logic [15:0] bus_tag;
      logic [1:0]  permit;
      logic [63:0] line_data;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic        retry;
      logic [7:0]  load_byte;
      logic        cmd_valid;
      logic        cmd_kind;
      logic [31:0] cmd_address;
      logic [15:0] cmd_tag;
      logic [1:0]  cmd_permit;
      logic [63:0] cmd_line;
   } rsp_type;

endpackage

// ===== sv/csac_exec.sv =====
// ----------------------------------------------------------------------------
// csac_exec
// Set evaluation: way lookup, fill victim choice, LRU touch and the result
// for one operation against one set row.
// ----------------------------------------------------------------------------
module csac_exec #(
   parameter int WAYS_LOG2       = csac_pkg::WAYS_LOG2_DEF,
   parameter int SETS_LOG2       = csac_pkg::SETS_LOG2_DEF,
   parameter int LINE_BYTES_LOG2 = csac_pkg::LINE_BYTES_LOG2_DEF
) (
   input  csac_pkg::req_type req,
   input  logic [((SETS_LOG2 > 0) ? SETS_LOG2 : 1)-1:0] set_idx,
   input  logic [(1<<WAYS_LOG2)-1:0][(32-SETS_LOG2-LINE_BYTES_LOG2)-1:0] tags_rd,
   input  logic [(1<<WAYS_LOG2)-1:0][1:0] perms_rd,
   input  logic [(1<<WAYS_LOG2)-1:0][WAYS_LOG2:0] ranks_rd,
   input  logic [(1<<WAYS_LOG2)-1:0][63:0] lines_rd,
   output logic [(1<<WAYS_LOG2)-1:0][(32-SETS_LOG2-LINE_BYTES_LOG2)-1:0] tags_wr,
   output logic [(1<<WAYS_LOG2)-1:0][1:0] perms_wr,
   output logic [(1<<WAYS_LOG2)-1:0][WAYS_LOG2:0] ranks_wr,
   output logic [(1<<WAYS_LOG2)-1:0][63:0] lines_wr,
   output csac_pkg::rsp_type rsp
);
   import csac_pkg::*;

   localparam int NWAYS = 1 << WAYS_LOG2;
   localparam int TW    = 32 - SETS_LOG2 - LINE_BYTES_LOG2;
   localparam int RW    = WAYS_LOG2 + 1;
   localparam int WW    = (WAYS_LOG2 > 0) ? WAYS_LOG2 : 1;
   localparam int SW    = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;
   localparam int OW    = (LINE_BYTES_LOG2 > 0) ? LINE_BYTES_LOG2 : 1;

   logic [TW-1:0]    tag;
   logic [OW-1:0]    offset;
   logic [5:0]       bitpos;
   logic             found;
   logic [WW-1:0]    way;
   logic [1:0]       held;
   logic             unr_found;
   logic [WW-1:0]    unr_way;
   logic [WW-1:0]    zero_way;
   logic             zero_found;
   logic [WW-1:0]    vict;
   logic             do_touch;
   logic [WW-1:0]    tway;
   logic signed [RW:0] cur;
   logic signed [RW:0] rk;
   logic [63:0]      bmask;
   logic [31:0]      wb_addr;

   assign tag    = req.address[31 -: TW];
   assign offset = (LINE_BYTES_LOG2 > 0) ? req.address[OW-1:0] : '0;
   assign bitpos = {3'(offset), 3'b000};
   assign bmask  = 64'hFF << bitpos;

   always_comb begin
      found      = 1'b0;
      way        = '0;
      unr_found  = 1'b0;
      unr_way    = '0;
      zero_found = 1'b0;
      zero_way   = '0;
      // downward scan leaves the lowest match
      for (int w = NWAYS - 1; w >= 0; w--) begin
         if (tags_rd[w] == tag) begin
            found = 1'b1;
            way   = WW'(w);
         end
         if (ranks_rd[w] == {RW{1'b1}}) begin
            unr_found = 1'b1;
            unr_way   = WW'(w);
         end
      end
      // upward scan leaves the highest way of rank zero
      for (int w = 0; w < NWAYS; w++) begin
         if (ranks_rd[w] == '0) begin
            zero_found = 1'b1;
            zero_way   = WW'(w);
         end
      end
   end

   assign held = found ? perms_rd[way] : PERM_INV;

   always_comb begin
      if (found)           vict = way;
      else if (unr_found)  vict = unr_way;
      else if (zero_found) vict = zero_way;
      else                 vict = '0;
   end

   assign wb_addr = (32'(tags_rd[vict]) << (SETS_LOG2 + LINE_BYTES_LOG2)) |
                    ((SETS_LOG2 > 0) ? (32'(set_idx) << LINE_BYTES_LOG2) : 32'd0);

   always_comb begin
      tags_wr  = tags_rd;
      perms_wr = perms_rd;
      ranks_wr = ranks_rd;
      lines_wr = lines_rd;
      rsp      = '0;
      do_touch = 1'b0;
      tway     = way;
      cur      = '0;
      rk       = '0;
      case (req.opcode)
         OP_LOAD: begin
            if (found && held != PERM_INV) begin
               rsp.hit       = 1'b1;
               rsp.load_byte = 8'(lines_rd[way] >> bitpos);
               do_touch      = 1'b1;
            end else begin
               rsp.retry = 1'b1;
               if (!req.retried) begin
                  rsp.cmd_valid   = 1'b1;
                  rsp.cmd_kind    = CMD_READ;
                  rsp.cmd_address = req.address;
                  rsp.cmd_tag     = req.bus_tag;
                  rsp.cmd_permit  = PERM_SHR;
               end
            end
         end
         OP_STORE: begin
            if (found && (held == PERM_EXC || held == PERM_MOD)) begin
               rsp.hit       = 1'b1;
               perms_wr[way] = PERM_MOD;
               lines_wr[way] = (lines_rd[way] & ~bmask) | ({56'd0, req.store_byte} << bitpos);
               do_touch      = 1'b1;
            end else begin
               rsp.retry = 1'b1;
               if (!req.retried) begin
                  rsp.cmd_valid   = 1'b1;
                  rsp.cmd_kind    = CMD_READ;
                  rsp.cmd_address = req.address;
                  rsp.cmd_tag     = req.bus_tag;
                  rsp.cmd_permit  = PERM_MOD;
               end
            end
         end
         OP_FILL: begin
            tway = vict;
            if (!found && ranks_rd[vict] != {RW{1'b1}}) begin
               rsp.cmd_valid   = 1'b1;
               rsp.cmd_kind    = CMD_WBACK;
               rsp.cmd_address = wb_addr;
               rsp.cmd_tag     = WB_TAG;
               rsp.cmd_permit  = perms_rd[vict];
               rsp.cmd_line    = lines_rd[vict];
            end
            tags_wr[vict]  = tag;
            perms_wr[vict] = req.permit;
            lines_wr[vict] = req.line_data;
            do_touch       = 1'b1;
         end
         OP_SNOOP_INV, OP_SNOOP_RD: begin
            if (found && held != PERM_INV) begin
               rsp.hit = 1'b1;
               if (req.opcode == OP_SNOOP_RD) begin
                  rsp.cmd_valid   = 1'b1;
                  rsp.cmd_kind    = CMD_READ;
                  rsp.cmd_address = req.address;
                  rsp.cmd_tag     = req.bus_tag;
                  rsp.cmd_permit  = held;
                  rsp.cmd_line    = lines_rd[way];
               end
               if (req.opcode == OP_SNOOP_INV || req.permit == PERM_MOD) begin
                  perms_wr[way] = PERM_INV;
                  ranks_wr[way] = {RW{1'b1}};
               end else begin
                  perms_wr[way] = PERM_SHR;
               end
            end
         end
         default: begin
         end
      endcase

      // touch: target becomes most recent, ranks above its old rank drop
      if (do_touch) begin
         cur = $signed({ranks_rd[tway][RW-1], ranks_rd[tway]});
         if (cur < 0) cur = '0;
         for (int w = 0; w < NWAYS; w++) begin
            rk = $signed({ranks_rd[w][RW-1], ranks_rd[w]});
            if (WW'(w) == tway)
               ranks_wr[w] = RW'(NWAYS - 1);
            else if (rk > cur)
               ranks_wr[w] = RW'(rk - 1);
         end
      end
   end

endmodule

// ===== sv/coherent_set_assoc_cache_lru.sv =====
// ----------------------------------------------------------------------------
// coherent_set_assoc_cache_lru
// Blocking MESI set-associative cache with exact LRU ranks.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Each operation reads
// the set row from the line store (registered read), evaluates it and writes it
// back, and the result appears on rsp_data for exactly one cycle with rsp_valid
// high; the receiver cannot stall it. A new start is taken in the same cycle the
// result is shown. After reset the line store is cleared one set per cycle, and
// busy stays high until all 2^SETS_LOG2 sets are cleared.
module coherent_set_assoc_cache_lru #(
   parameter int WAYS_LOG2       = csac_pkg::WAYS_LOG2_DEF,
   parameter int SETS_LOG2       = csac_pkg::SETS_LOG2_DEF,
   parameter int LINE_BYTES_LOG2 = csac_pkg::LINE_BYTES_LOG2_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  csac_pkg::req_type req_data,
   output logic              rsp_valid,
   output csac_pkg::rsp_type rsp_data
);
   import csac_pkg::*;

   localparam int NWAYS = 1 << WAYS_LOG2;
   localparam int NSETS = 1 << SETS_LOG2;
   localparam int TW    = 32 - SETS_LOG2 - LINE_BYTES_LOG2;
   localparam int RW    = WAYS_LOG2 + 1;
   localparam int SW    = (SETS_LOG2 > 0) ? SETS_LOG2 : 1;

   logic [NWAYS-1:0][TW-1:0] tag_mem  [NSETS];
   logic [NWAYS-1:0][1:0]    perm_mem [NSETS];
   logic [NWAYS-1:0][RW-1:0] rank_mem [NSETS];
   logic [NWAYS-1:0][63:0]   line_mem [NSETS];

   state_type state_ff, state_in;
   logic [SW:0]  clr_cnt_ff, clr_cnt_in;
   req_type      req_ff;
   logic [SW-1:0] set_idx;
   logic [NWAYS-1:0][TW-1:0] tags_rd_ff, tags_wr;
   logic [NWAYS-1:0][1:0]    perms_rd_ff, perms_wr;
   logic [NWAYS-1:0][RW-1:0] ranks_rd_ff, ranks_wr;
   logic [NWAYS-1:0][63:0]   lines_rd_ff, lines_wr;
   rsp_type      rsp_calc;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_data_ff;
   logic         accept;
   logic         mem_we;
   logic         clr_we;
   logic [SW-1:0] wr_idx;

   assign set_idx = (SETS_LOG2 > 0) ? req_ff.address[LINE_BYTES_LOG2 +: SW] : '0;
   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;

   csac_exec #(
      .WAYS_LOG2       (WAYS_LOG2),
      .SETS_LOG2       (SETS_LOG2),
      .LINE_BYTES_LOG2 (LINE_BYTES_LOG2)
   ) u_exec (
      .req      (req_ff),
      .set_idx  (set_idx),
      .tags_rd  (tags_rd_ff),
      .perms_rd (perms_rd_ff),
      .ranks_rd (ranks_rd_ff),
      .lines_rd (lines_rd_ff),
      .tags_wr  (tags_wr),
      .perms_wr (perms_wr),
      .ranks_wr (ranks_wr),
      .lines_wr (lines_wr),
      .rsp      (rsp_calc)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_cnt_ff == (SW+1)'(NSETS - 1)) state_in = S_IDLE;
         S_IDLE:  if (start) state_in = S_READ;
         S_READ:  state_in = S_EXEC;
         S_EXEC:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      clr_we       = 1'b0;
      mem_we       = 1'b0;
      rsp_valid_in = 1'b0;
      clr_cnt_in   = clr_cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
         end
         S_EXEC: begin
            mem_we       = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign wr_idx = clr_we ? clr_cnt_ff[SW-1:0] : set_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
      if (rsp_valid_in) rsp_data_ff <= rsp_calc;
   end

   // line store: one row per set, registered read
   always_ff @(posedge clock) begin
      if (clr_we) begin
         tag_mem[wr_idx]  <= '0;
         perm_mem[wr_idx] <= '0;
         rank_mem[wr_idx] <= '1;
         line_mem[wr_idx] <= '0;
      end else if (mem_we) begin
         tag_mem[wr_idx]  <= tags_wr;
         perm_mem[wr_idx] <= perms_wr;
         rank_mem[wr_idx] <= ranks_wr;
         line_mem[wr_idx] <= lines_wr;
      end
      tags_rd_ff  <= tag_mem[set_idx];
      perms_rd_ff <= perm_mem[set_idx];
      ranks_rd_ff <= rank_mem[set_idx];
      lines_rd_ff <= line_mem[set_idx];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_valid_ff ? rsp_data_ff : '0;

endmodule

// ===== tb/sv/csac_checker.sv =====
// ----------------------------------------------------------------------------
// csac_checker
// Watches the request and response channels of the cache, keeps its own copy
// of tags, permits, LRU ranks and line bytes, and checks every response
// against the predicted one.
// ----------------------------------------------------------------------------
module csac_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  csac_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  csac_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending
);
   import csac_pkg::*;

   localparam int NWAYS = 1 << WAYS_LOG2_DEF;
   localparam int NSETS = 1 << SETS_LOG2_DEF;
   localparam int TSHIFT = LINE_BYTES_LOG2_DEF + SETS_LOG2_DEF;

   logic [31-TSHIFT:0] tag_mem [NSETS][NWAYS];
   logic [1:0]         perm_mem[NSETS][NWAYS];
   int                 rank_mem[NSETS][NWAYS];
   logic [63:0]        data_mem[NSETS][NWAYS];
   rsp_type            expected_rsps[$];

   initial pending = 0;

   task automatic make_recent(input int s, input int w);
      int cur;
      cur = (rank_mem[s][w] < 0) ? 0 : rank_mem[s][w];
      rank_mem[s][w] = NWAYS;
      for (int i = 0; i < NWAYS; i++)
         if (rank_mem[s][i] > cur) rank_mem[s][i]--;
   endtask

   task automatic cache_op(input req_type r, output rsp_type o);
      int s, way, v, bitpos;
      logic [31-TSHIFT:0] t;
      logic [1:0] held;
      logic found;
      s = r.address[TSHIFT-1:LINE_BYTES_LOG2_DEF];
      t = r.address[31:TSHIFT];
      bitpos = r.address[LINE_BYTES_LOG2_DEF-1:0] * 8;
      way = -1;
      for (int i = NWAYS - 1; i >= 0; i--)
         if (tag_mem[s][i] == t) way = i;
      held = (way >= 0) ? perm_mem[s][way] : PERM_INV;
      o = '0;
      case (r.opcode)
         OP_LOAD, OP_STORE: begin
            if (way >= 0 && held >= ((r.opcode == OP_LOAD) ? PERM_SHR : PERM_EXC)) begin
               o.hit = 1'b1;
               make_recent(s, way);
               if (r.opcode == OP_LOAD) begin
                  o.load_byte = data_mem[s][way][bitpos +: 8];
               end else begin
                  perm_mem[s][way] = PERM_MOD;
                  data_mem[s][way][bitpos +: 8] = r.store_byte;
               end
            end else begin
               o.retry = 1'b1;
               if (!r.retried) begin
                  o.cmd_valid   = 1'b1;
                  o.cmd_kind    = CMD_READ;
                  o.cmd_address = r.address;
                  o.cmd_tag     = r.bus_tag;
                  o.cmd_permit  = (r.opcode == OP_LOAD) ? PERM_SHR : PERM_MOD;
               end
            end
         end
         OP_FILL: begin
            v = 0;
            if (way >= 0) begin
               v = way;
            end else begin
               found = 1'b0;
               for (int i = 0; i < NWAYS; i++)
                  if (!found && rank_mem[s][i] == -1) begin
                     v = i;
                     found = 1'b1;
                  end
               if (!found)
                  for (int i = 0; i < NWAYS; i++)
                     if (rank_mem[s][i] == 0) v = i;
               // ranked victim goes back to the next level
               if (rank_mem[s][v] != -1) begin
                  o.cmd_valid   = 1'b1;
                  o.cmd_kind    = CMD_WBACK;
                  o.cmd_address = {tag_mem[s][v], 6'(s), {LINE_BYTES_LOG2_DEF{1'b0}}};
                  o.cmd_tag     = WB_TAG;
                  o.cmd_permit  = perm_mem[s][v];
                  o.cmd_line    = data_mem[s][v];
               end
            end
            tag_mem[s][v]  = t;
            perm_mem[s][v] = r.permit;
            make_recent(s, v);
            data_mem[s][v] = r.line_data;
         end
         OP_SNOOP_INV, OP_SNOOP_RD: begin
            if (way >= 0 && held != PERM_INV) begin
               o.hit = 1'b1;
               if (r.opcode == OP_SNOOP_RD) begin
                  o.cmd_valid   = 1'b1;
                  o.cmd_kind    = CMD_READ;
                  o.cmd_address = r.address;
                  o.cmd_tag     = r.bus_tag;
                  o.cmd_permit  = held;
                  o.cmd_line    = data_mem[s][way];
               end
               if (r.opcode == OP_SNOOP_INV || r.permit == PERM_MOD) begin
                  perm_mem[s][way] = PERM_INV;
                  rank_mem[s][way] = -1;
               end else begin
                  perm_mem[s][way] = PERM_SHR;
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type e, a;
      if (reset) begin
         for (int s = 0; s < NSETS; s++)
            for (int w = 0; w < NWAYS; w++) begin
               tag_mem[s][w]  = '0;
               perm_mem[s][w] = PERM_INV;
               rank_mem[s][w] = -1;
               data_mem[s][w] = '0;
            end
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            a = rsp_data;
            if (expected_rsps.size() == 0) begin
               $error("response with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_rsps.pop_front();
               if (a !== e) begin
                  fail_count <= fail_count + 1;
                  if (a.hit !== e.hit)
                     $error("hit: expected %0h actual %0h", e.hit, a.hit);
                  if (a.retry !== e.retry)
                     $error("retry: expected %0h actual %0h", e.retry, a.retry);
                  if (a.load_byte !== e.load_byte)
                     $error("load_byte: expected %0h actual %0h", e.load_byte, a.load_byte);
                  if (a.cmd_valid !== e.cmd_valid)
                     $error("cmd_valid: expected %0h actual %0h", e.cmd_valid, a.cmd_valid);
                  if (a.cmd_kind !== e.cmd_kind)
                     $error("cmd_kind: expected %0h actual %0h", e.cmd_kind, a.cmd_kind);
                  if (a.cmd_address !== e.cmd_address)
                     $error("cmd_address: expected %0h actual %0h",
                            e.cmd_address, a.cmd_address);
                  if (a.cmd_tag !== e.cmd_tag)
                     $error("cmd_tag: expected %0h actual %0h", e.cmd_tag, a.cmd_tag);
                  if (a.cmd_permit !== e.cmd_permit)
                     $error("cmd_permit: expected %0h actual %0h", e.cmd_permit, a.cmd_permit);
                  if (a.cmd_line !== e.cmd_line)
                     $error("cmd_line: expected %0h actual %0h", e.cmd_line, a.cmd_line);
               end
            end
         end
         // a transfer taken in the same cycle a response shows is predicted after it
         if (start && !busy) begin
            cache_op(req_data, e);
            expected_rsps.push_back(e);
         end
      end
      pending = expected_rsps.size();
   end

endmodule

// ===== tb/sv/coherent_set_assoc_cache_lru_tb.sv =====
// ----------------------------------------------------------------------------
// coherent_set_assoc_cache_lru_tb
// Drives directed and random cache traffic (miss, fill, hit, upgrade,
// eviction, snoops) with random gaps; a checker predicts every response.
// ----------------------------------------------------------------------------
module coherent_set_assoc_cache_lru_tb;
   import csac_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   int      stall_cycles = 0;
   logic    gaps_on = 1'b1;

   always #5 clock = ~clock;

   coherent_set_assoc_cache_lru uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   csac_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending(pending)
   );

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic issue(input req_type r);
      if (gaps_on && $urandom_range(99) < 30) begin
         start = 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      start = 1'b1;
      req_data = r;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   function automatic req_type op_at(input logic [2:0] opc, input logic [31:0] addr,
                                     input logic [1:0] perm, input logic retried);
      req_type r;
      r.opcode     = opc;
      r.address    = addr;
      r.store_byte = 8'($urandom);
      r.retried    = retried;
      r.bus_tag    = 16'($urandom);
      r.permit     = perm;
      r.line_data  = {$urandom, $urandom};
      return r;
   endfunction

   // small pools of sets and tags keep hits, upgrades and evictions common
   function automatic logic [31:0] pick_address();
      logic [22:0] t;
      logic [5:0]  s;
      if ($urandom_range(99) < 5) return $urandom;
      case ($urandom_range(5))
         0: t = '0;
         1: t = '1;
         default: t = 23'($urandom_range(4));
      endcase
      case ($urandom_range(3))
         0: s = '0;
         1: s = '1;
         default: s = 6'($urandom_range(3, 1));
      endcase
      return {t, s, 3'($urandom)};
   endfunction

   initial begin
      req_type r;
      logic [31:0] a;
      logic [2:0]  opc;
      int sel;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed
      a = 32'hFFFF_FFFF;
      issue(op_at(OP_LOAD, 32'h0, PERM_INV, 1'b0));
      issue(op_at(OP_LOAD, 32'h0, PERM_INV, 1'b1));
      issue(op_at(OP_STORE, a, PERM_INV, 1'b0));
      r = op_at(OP_FILL, a, PERM_EXC, 1'b0);
      r.line_data = '1;
      issue(r);
      issue(op_at(OP_LOAD, a, PERM_INV, 1'b0));
      r = op_at(OP_STORE, a, PERM_INV, 1'b1);
      r.store_byte = 8'h00;
      issue(r);
      issue(op_at(OP_LOAD, a, PERM_INV, 1'b0));
      issue(op_at(OP_FILL, 32'h0000_0208, PERM_SHR, 1'b0));
      issue(op_at(OP_STORE, 32'h0000_0208, PERM_INV, 1'b0));
      issue(op_at(OP_STORE, 32'h0000_0208, PERM_INV, 1'b1));
      // five tags in one set force a writeback of the LRU way
      for (int i = 0; i < 5; i++)
         issue(op_at(OP_FILL, {23'(i + 8), 6'h3F, 3'd0}, 2'(i % 3 + 1), 1'b0));
      issue(op_at(OP_FILL, {23'd12, 6'h3F, 3'd5}, PERM_MOD, 1'b0));
      issue(op_at(OP_SNOOP_RD, {23'd12, 6'h3F, 3'd1}, PERM_SHR, 1'b0));
      issue(op_at(OP_SNOOP_RD, {23'd11, 6'h3F, 3'd2}, PERM_MOD, 1'b0));
      issue(op_at(OP_SNOOP_INV, {23'd10, 6'h3F, 3'd0}, PERM_INV, 1'b0));
      issue(op_at(OP_SNOOP_INV, 32'h1234_5678, PERM_INV, 1'b0));
      issue(op_at(OP_FILL, {23'd13, 6'h3F, 3'd0}, PERM_EXC, 1'b0));
      for (int i = 5; i < 8; i++) issue(op_at(3'(i), $urandom, 2'($urandom), 1'b0));

      // random traffic; miss often followed by its fill and a retried access
      for (int n = 0; n < 1750; n++) begin
         gaps_on = !(n >= 600 && n < 800);
         if (n == 1000) begin
            start = 1'b0;
            while (pending != 0) @(negedge clock);
         end
         a = pick_address();
         sel = $urandom_range(99);
         opc = sel < 30 ? OP_LOAD : sel < 55 ? OP_STORE : sel < 78 ? OP_FILL :
               sel < 86 ? OP_SNOOP_INV : sel < 98 ? OP_SNOOP_RD : 3'($urandom_range(7, 5));
         r = op_at(opc, a, 2'($urandom), ($urandom_range(99) < 20));
         issue(r);
         if ((opc == OP_LOAD || opc == OP_STORE) && $urandom_range(99) < 40) begin
            issue(op_at(OP_FILL, a, (opc == OP_LOAD) ? 2'($urandom_range(3, 1)) :
                        2'($urandom_range(3, 2)), 1'b0));
            r.retried = 1'b1;
            issue(r);
            n += 2;
         end
      end
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
